FILE: sv/spk_pkg.sv
package spk_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned KEY_SLOTS     = 27;
  localparam int unsigned ROUND_COUNT_D = 27;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // control for one key cell
  typedef struct packed {
    logic wr;     // write key_word into this cell
    logic shift;  // take the neighbor's key
  } key_ctl_t;

  // control for the round datapath
  typedef struct packed {
    logic load;   // capture ciphertext words
    logic step;   // run one round
  } rnd_ctl_t;

endpackage

FILE: sv/spk_key_cell.sv
module spk_key_cell (
  input  logic                         clk_i,
  input  spk_pkg::key_ctl_t            ctl_i,
  input  logic [spk_pkg::WORD_W-1:0]   wr_key_i,
  input  logic [spk_pkg::WORD_W-1:0]   prev_key_i,
  output logic [spk_pkg::WORD_W-1:0]   key_o
);

  logic [spk_pkg::WORD_W-1:0] key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (ctl_i.wr) begin
      key_d = wr_key_i;
    end else if (ctl_i.shift) begin
      key_d = prev_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

FILE: sv/spk_round_unit.sv
module spk_round_unit (
  input  logic                         clk_i,
  input  spk_pkg::rnd_ctl_t            ctl_i,
  input  logic [spk_pkg::WORD_W-1:0]   ct_low_i,
  input  logic [spk_pkg::WORD_W-1:0]   ct_high_i,
  input  logic [spk_pkg::WORD_W-1:0]   rkey_i,
  output logic [spk_pkg::WORD_W-1:0]   y_o,
  output logic [spk_pkg::WORD_W-1:0]   x_o
);

  logic [spk_pkg::WORD_W-1:0] y_q, y_d, x_q, x_d;
  logic [spk_pkg::WORD_W-1:0] y_mix, y_rnd, x_diff, x_rnd;

  always_comb begin
    y_mix  = y_q ^ x_q;
    y_rnd  = {y_mix[2:0], y_mix[spk_pkg::WORD_W-1:3]};
    x_diff = (x_q ^ rkey_i) - y_rnd;
    x_rnd  = {x_diff[spk_pkg::WORD_W-9:0], x_diff[spk_pkg::WORD_W-1:spk_pkg::WORD_W-8]};
  end

  always_comb begin
    y_d = y_q;
    x_d = x_q;
    if (ctl_i.load) begin
      y_d = ct_low_i;
      x_d = ct_high_i;
    end else if (ctl_i.step) begin
      y_d = y_rnd;
      x_d = x_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    x_q <= x_d;
  end

  assign y_o = y_q;
  assign x_o = x_q;

endmodule

FILE: sv/speck64_128_block_decrypt_top.sv
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// request   | start / busy       | cmd_i, key_index_i, key_word_i, block_low_i/high_i
// result    | done_o (1 cycle)   | plain_low_o, plain_high_o
//
// A decrypt holds busy from the accepting edge through the last round, one round per
// clock, the round keys circulating through a ring of ROUND_COUNT key cells. done_o
// follows for one cycle with busy already low, so the next request can be taken then.
// A key load gives no result.
// Reset clears the control only; round keys are undefined until loaded.
// The result stays on the ports until the next decrypt is accepted; the receiver cannot stall it.
module speck64_128_block_decrypt_top #(
  parameter int unsigned ROUND_COUNT = spk_pkg::ROUND_COUNT_D
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [spk_pkg::IDX_W-1:0]    key_index_i,
  input  logic [spk_pkg::WORD_W-1:0]   key_word_i,
  input  logic [spk_pkg::WORD_W-1:0]   block_low_i,
  input  logic [spk_pkg::WORD_W-1:0]   block_high_i,
  output logic                         done_o,
  output logic [spk_pkg::WORD_W-1:0]   plain_low_o,
  output logic [spk_pkg::WORD_W-1:0]   plain_high_o
);

  localparam int unsigned CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, last_round;

  logic [spk_pkg::WORD_W-1:0] ring_key [ROUND_COUNT];
  spk_pkg::rnd_ctl_t          rnd_ctl;

  assign accept     = start && !busy_q;
  assign last_round = (cnt_q == CNT_W'(ROUND_COUNT - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last_round) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (accept && (cmd_i == spk_pkg::CMD_DECRYPT)) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Ring of key cells: cell i holds k[i] at rest. While busy the ring rotates up by
  // one each round, so the top cell shows k[N-1] .. k[0] and the ring is home again
  // after the last round. Slots at or above ROUND_COUNT are never read, so loads
  // there are dropped.
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
    spk_pkg::key_ctl_t ctl;
    assign ctl.wr    = accept && (cmd_i == spk_pkg::CMD_LOAD)
                       && (key_index_i == spk_pkg::IDX_W'(i));
    assign ctl.shift = busy_q;

    spk_key_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .wr_key_i   (key_word_i),
      .prev_key_i (ring_key[(i == 0) ? ROUND_COUNT - 1 : i - 1]),
      .key_o      (ring_key[i])
    );
  end

  assign rnd_ctl.load = accept && (cmd_i == spk_pkg::CMD_DECRYPT);
  assign rnd_ctl.step = busy_q;

  spk_round_unit u_round (
    .clk_i     (clk_i),
    .ctl_i     (rnd_ctl),
    .ct_low_i  (block_low_i),
    .ct_high_i (block_high_i),
    .rkey_i    (ring_key[ROUND_COUNT-1]),
    .y_o       (plain_low_o),
    .x_o       (plain_high_o)
  );

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

FILE: sv/spk_checker.sv
module spk_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cmd_i,
  input logic done_o
);

  // a result only ever ends a run of rounds
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("done without preceding rounds");

  a_decrypt_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == spk_pkg::CMD_DECRYPT)) |=> busy)
    else $error("decrypt request did not start rounds");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == spk_pkg::CMD_LOAD)) |=> (!busy && !done_o))
    else $error("key load started rounds or gave a result");

  a_busy_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("rounds ended without a result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind speck64_128_block_decrypt_top spk_checker u_spk_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o)
);
